>>> design/mhd_pkg.sv
// ----------------------------------------------------------------------------
// mhd_pkg
// Shared types, constants and helpers of the mipmap half downsampler.
// ----------------------------------------------------------------------------
package mhd_pkg;

  // Default size limits of the block.
  localparam int DEF_MAX_WIDTH      = 2048;
  localparam int DEF_MAX_HEIGHT     = 2048;
  localparam int DEF_MAX_COMPONENTS = 4;

  // Fixed field widths.
  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = 9;
  localparam int TOTAL_W  = 10;
  localparam int CFG_W    = 12;
  localparam int CIDX_W   = 2;
  localparam int FMT_W    = 3;
  localparam int COMP_W   = 2;

  // Even-column hold registers, one per component code.
  localparam int HOLD_DEPTH = 4;

  // Queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd2;

  // Format codes.
  localparam logic [FMT_W-1:0] FMT_RGB        = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RGBA       = 3'd1;
  localparam logic [FMT_W-1:0] FMT_LUMINANCE  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_LUM_ALPHA  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_ALPHA      = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [FMT_W-1:0] FORMAT_RESET = FMT_RGBA;
  localparam logic [CFG_W-1:0] SIZE_RESET   = 12'd1;

  // Configuration write transaction.
  typedef struct packed {
    logic              valid;
    logic [CIDX_W-1:0] index;
    logic [CFG_W-1:0]  data;
  } cfg_wr_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic             err;
    logic             use_row;
    logic             eoi;
    logic [SUM_W-1:0] hsum;
  } job_t;

  // Queue entry: job plus the line buffer word read for it.
  typedef struct packed {
    job_t             job;
    logic [SUM_W-1:0] rowsum;
  } q_entry_t;

  // Components per pixel of a format; zero marks an invalid code.
  function automatic logic [FMT_W-1:0] comps_of(input logic [FMT_W-1:0] code);
    logic [FMT_W-1:0] n;
    case (code)
      FMT_RGB:       n = 3'd3;
      FMT_RGBA:      n = 3'd4;
      FMT_LUMINANCE: n = 3'd1;
      FMT_LUM_ALPHA: n = 3'd2;
      FMT_ALPHA:     n = 3'd1;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  // Address bits of a memory, at least one.
  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> design/mhd_ram.sv
// ----------------------------------------------------------------------------
// mhd_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mhd_ram #(
  parameter int WIDTH  = 9,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = mhd_pkg::addr_bits(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mhd_front.sv
// ----------------------------------------------------------------------------
// mhd_front
// Accepts samples, tracks the raster position, forms horizontal pair sums,
// drives the line buffer and hands classified items to the queue.
// ----------------------------------------------------------------------------
module mhd_front #(
  parameter int MAX_WIDTH      = mhd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = mhd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_COMPONENTS = mhd_pkg::DEF_MAX_COMPONENTS,
  parameter int ADDR_W         = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mhd_pkg::cfg_wr_t              cfg_wr_i,
  input  logic                          accept_i,
  input  logic [mhd_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                          ram_we_o,
  output logic [ADDR_W-1:0]             ram_addr_o,
  output logic [mhd_pkg::SUM_W-1:0]     ram_wdata_o,
  output logic                          job_valid_o,
  output mhd_pkg::job_t                 job_o
);
  import mhd_pkg::*;

  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XYW    = (XW > YW) ? XW : YW;
  localparam int CMP_W  = ((XYW > CFG_W) ? XYW : CFG_W) + 1;
  localparam int IDX_FW = XW + 3;

  logic [FMT_W-1:0]    format_q;
  logic [CFG_W-1:0]    width_q, height_q;
  logic [XW-1:0]       x_q, x_d;
  logic [YW-1:0]       y_q, y_d;
  logic [COMP_W-1:0]   c_q, c_d;
  logic [SAMPLE_W-1:0] hold_q [HOLD_DEPTH];
  logic                job_valid_q;
  job_t                job_q;

  logic [FMT_W-1:0]  comps;
  logic [CMP_W-1:0]  w_ext, h_ext, x_ext, y_ext;
  logic              cfg_err, w_one, h_one;
  logic              hready, hold_we, vready, step;
  logic              last_comp, last_col, last_row, dx_end, dy_end;
  logic [SUM_W-1:0]  hsum;
  logic [IDX_FW-1:0] idx_full;

  // Configuration check and position decode.
  always_comb begin
    comps   = comps_of(format_q);
    w_ext   = CMP_W'(width_q);
    h_ext   = CMP_W'(height_q);
    x_ext   = CMP_W'(x_q);
    y_ext   = CMP_W'(y_q);
    cfg_err = (comps == '0) || (comps > FMT_W'(MAX_COMPONENTS)) ||
              (width_q == '0) || (height_q == '0) ||
              (w_ext > CMP_W'(MAX_WIDTH)) || (h_ext > CMP_W'(MAX_HEIGHT));
    w_one   = (width_q == CFG_W'(1));
    h_one   = (height_q == CFG_W'(1));

    last_comp = ({1'b0, c_q} + 3'd1) >= comps;
    last_col  = (x_ext + CMP_W'(1)) >= w_ext;
    last_row  = (y_ext + CMP_W'(1)) >= h_ext;
    dx_end    = w_one || (((x_ext >> 1) + CMP_W'(1)) == (w_ext >> 1));
    dy_end    = h_one || (((y_ext >> 1) + CMP_W'(1)) == (h_ext >> 1));
  end

  // Horizontal pair: a single column doubles, an odd column adds its hold.
  always_comb begin
    hold_we = 1'b0;
    if (w_one) begin
      hsum   = {sample_i, 1'b0};
      hready = 1'b1;
    end else if (!x_q[0]) begin
      hsum    = '0;
      hready  = 1'b0;
      hold_we = (x_ext + CMP_W'(1)) < w_ext;
    end else begin
      hsum   = SUM_W'(hold_q[c_q]) + SUM_W'(sample_i);
      hready = 1'b1;
    end
  end

  // Line buffer access: even rows store, odd rows read back.
  always_comb begin
    step     = accept_i && !cfg_err;
    idx_full = IDX_FW'(x_q >> 1) * IDX_FW'(comps) + IDX_FW'(c_q);
    ram_addr_o  = idx_full[ADDR_W-1:0];
    ram_wdata_o = hsum;
    ram_we_o    = step && hready && !h_one && !y_q[0] &&
                  ((y_ext + CMP_W'(1)) < h_ext);
    vready      = hready && (h_one || y_q[0]);
  end

  // Next raster position.
  always_comb begin
    c_d = c_q + COMP_W'(1);
    x_d = x_q;
    y_d = y_q;
    if (last_comp) begin
      c_d = '0;
      x_d = x_q + XW'(1);
      if (last_col) begin
        x_d = '0;
        y_d = last_row ? '0 : y_q + YW'(1);
      end
    end
  end

  // Configuration registers, counters and column hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FORMAT_RESET;
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
      x_q      <= '0;
      y_q      <= '0;
      c_q      <= '0;
      for (int i = 0; i < HOLD_DEPTH; i++) begin
        hold_q[i] <= '0;
      end
    end else if (cfg_wr_i.valid) begin
      case (cfg_wr_i.index)
        REG_FORMAT: format_q <= cfg_wr_i.data[FMT_W-1:0];
        REG_WIDTH:  width_q  <= cfg_wr_i.data;
        REG_HEIGHT: height_q <= cfg_wr_i.data;
        default:    ;
      endcase
      // Any write restarts the image.
      x_q <= '0;
      y_q <= '0;
      c_q <= '0;
      for (int i = 0; i < HOLD_DEPTH; i++) begin
        hold_q[i] <= '0;
      end
    end else if (step) begin
      x_q <= x_d;
      y_q <= y_d;
      c_q <= c_d;
      if (hold_we) begin
        hold_q[c_q] <= sample_i;
      end
    end
  end

  // Job register, aligned with the line buffer read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else begin
      job_valid_q <= accept_i && (cfg_err || vready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      job_q.err     <= cfg_err;
      job_q.use_row <= !h_one;
      job_q.eoi     <= !cfg_err && dx_end && dy_end && last_comp;
      job_q.hsum    <= hsum;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

>>> design/mhd_queue.sv
// ----------------------------------------------------------------------------
// mhd_queue
// Short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module mhd_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  mhd_pkg::q_entry_t          entry_i,
  input  logic                       pop_i,
  output mhd_pkg::q_entry_t          entry_o,
  output logic [mhd_pkg::QCNT_W-1:0] count_o
);
  import mhd_pkg::*;

  q_entry_t          slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

>>> design/mhd_back.sv
// ----------------------------------------------------------------------------
// mhd_back
// Completes the 2x2 sum of a queued job, rounds it and holds the result in
// the output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module mhd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mhd_pkg::QCNT_W-1:0]   q_count_i,
  input  mhd_pkg::q_entry_t            q_entry_i,
  output logic                         pop_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [mhd_pkg::SAMPLE_W-1:0] out_value_o,
  output logic                         end_of_image_o,
  output logic                         config_error_o
);
  import mhd_pkg::*;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] value_q;
  logic                eoi_q, err_q;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W:0]    rounded;
  logic                pop;

  // Vertical pair and rounding.
  always_comb begin
    if (q_entry_i.job.use_row) begin
      total = TOTAL_W'(q_entry_i.rowsum) + TOTAL_W'(q_entry_i.job.hsum);
    end else begin
      total = {q_entry_i.job.hsum, 1'b0};
    end
    rounded = (TOTAL_W + 1)'(total) + (TOTAL_W + 1)'(2);
    pop     = (q_count_i != '0) && (!out_valid_q || !out_stall_i);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      value_q <= q_entry_i.job.err ? '0 : rounded[TOTAL_W-1:2];
      eoi_q   <= q_entry_i.job.eoi && !q_entry_i.job.err;
      err_q   <= q_entry_i.job.err;
    end
  end

  assign pop_o          = pop;
  assign out_valid_o    = out_valid_q;
  assign out_value_o    = value_q;
  assign end_of_image_o = eoi_q;
  assign config_error_o = err_q;

endmodule

>>> design/mipmap_half_downsampler_core.sv
// ----------------------------------------------------------------------------
// mipmap_half_downsampler_core
// Halves a raster image of 8-bit components with a 2x2 box filter.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while in_stall_o is low; the line buffer takes one
// access per sample.
// Path: after the edge that takes its last sample, a result passes the line
// buffer read and job register, the queue and the output register.
// Reset: counters, holds and queue clear at once; the line buffer is not
// cleared, since each entry is written on an even row before it is read.
module mipmap_half_downsampler_core #(
  parameter int MAX_WIDTH      = mhd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = mhd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_COMPONENTS = mhd_pkg::DEF_MAX_COMPONENTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mhd_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [mhd_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mhd_pkg::SAMPLE_W-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mhd_pkg::SAMPLE_W-1:0] out_value_o,
  output logic                         end_of_image_o,
  output logic                         config_error_o
);
  import mhd_pkg::*;

  localparam int ROW_DEPTH = (MAX_WIDTH / 2) * MAX_COMPONENTS;
  localparam int ADDR_W    = addr_bits(ROW_DEPTH);

  cfg_wr_t           cfg_wr;
  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [SUM_W-1:0]  ram_wdata, ram_rdata;
  logic              job_valid;
  job_t              job;
  q_entry_t          push_entry, head_entry;
  logic [QCNT_W-1:0] q_count;
  logic              pop;

  // Configuration writes are always taken.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // Hold off input while the queue could not take the job in flight plus one.
  assign in_stall_o = (q_count + QCNT_W'(job_valid)) >= QCNT_W'(QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  mhd_front #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .ADDR_W         (ADDR_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .accept_i    (accept),
    .sample_i    (sample_i),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // Line buffer of even-row pair sums.
  mhd_ram #(
    .WIDTH  (SUM_W),
    .DEPTH  (ROW_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  assign push_entry.job    = job;
  assign push_entry.rowsum = ram_rdata;

  mhd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .count_o (q_count)
  );

  mhd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_count_i      (q_count),
    .q_entry_i      (head_entry),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_value_o    (out_value_o),
    .end_of_image_o (end_of_image_o),
    .config_error_o (config_error_o)
  );

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  // The back part pops only a queue that holds a job.
  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_count != '0))
    else $error("pop from empty queue");

  // A pushed job is in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |=> (q_count != '0))
    else $error("pushed job missing from queue");

  // An error result carries a zero value and no image end.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && config_error_o) |-> ((out_value_o == '0) && !end_of_image_o))
    else $error("error result with payload");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mipmap_half_downsampler_core. It streams sample
// bytes under a range of formats and sizes, random stalls and gaps on both
// sides, and compares every output transaction with a local 2x2 box-filter
// predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mhd_pkg::*;

  // Index past the register list; a write there only restarts the image.
  localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;
  // Range of format codes that the block rejects.
  localparam logic [FMT_W-1:0] FMT_BAD_FIRST = 3'd5;
  localparam logic [FMT_W-1:0] FMT_BAD_LAST  = 3'd7;
  localparam int CFG_MAX       = (1 << CFG_W) - 1;
  localparam int LINE_DEPTH    = (DEF_MAX_WIDTH / 2) * DEF_MAX_COMPONENTS;
  localparam int MAX_GAP       = 18;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int LARGE_CUT     = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int PARTIAL_CAP   = 480;

  // Sample patterns of one burst.
  typedef enum int {PAT_RANDOM, PAT_FULL, PAT_EMPTY, PAT_ALTERNATE} pattern_e;

  // One destination component as the block reports it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                eoi;
    logic                err;
  } dest_comp_t;

  // Box-filter predictor and queue of destination components still awaited.
  class halfsize_scoreboard;
    logic [FMT_W-1:0]    format_code;
    logic [CFG_W-1:0]    src_width;
    logic [CFG_W-1:0]    src_height;
    logic [SUM_W-1:0]    line_sums [LINE_DEPTH];
    logic [SAMPLE_W-1:0] even_hold [HOLD_DEPTH];
    int unsigned         col;
    int unsigned         row;
    int unsigned         comp;
    dest_comp_t          awaited [$];
    int                  errors;

    function new();
      format_code = FORMAT_RESET;
      src_width   = SIZE_RESET;
      src_height  = SIZE_RESET;
      errors      = 0;
      foreach (line_sums[i]) line_sums[i] = '0;
      restart();
    endfunction

    // Any register write starts a fresh image.
    function void restart();
      col  = 0;
      row  = 0;
      comp = 0;
      foreach (even_hold[i]) even_hold[i] = '0;
    endfunction

    function int unsigned pixel_comps();
      case (format_code)
        FMT_RGB:       return 3;
        FMT_RGBA:      return 4;
        FMT_LUMINANCE: return 1;
        FMT_LUM_ALPHA: return 2;
        FMT_ALPHA:     return 1;
        default:       return 0;
      endcase
    endfunction

    function bit config_ok();
      return pixel_comps() != 0 && src_width != 0 && src_height != 0 &&
             src_width <= DEF_MAX_WIDTH && src_height <= DEF_MAX_HEIGHT;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_config(logic [CIDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_FORMAT: format_code = data[FMT_W-1:0];
        REG_WIDTH:  src_width = data;
        REG_HEIGHT: src_height = data;
        default: ;
      endcase
      restart();
    endfunction

    // Advances the image position by one accepted byte and queues the
    // destination component it completes, if any.
    function void note_sample(logic [SAMPLE_W-1:0] s);
      int unsigned comps, c, x, y, dw, dh, dx, dy, idx, hsum, total;
      bit          hready, vready;
      dest_comp_t  r;
      comps = pixel_comps();
      if (!config_ok()) begin
        r.value = '0;
        r.eoi   = 1'b0;
        r.err   = 1'b1;
        awaited.push_back(r);
        return;
      end
      c      = comp;
      x      = col;
      y      = row;
      hsum   = 0;
      total  = 0;
      hready = 1'b0;
      vready = 1'b0;
      dw = (src_width > 1) ? src_width / 2 : 1;
      dh = (src_height > 1) ? src_height / 2 : 1;
      dx = (src_width > 1) ? x >> 1 : 0;
      dy = (src_height > 1) ? y >> 1 : 0;

      // Horizontal pair; a one-pixel-wide image doubles each sample.
      if (src_width == 1) begin
        hsum   = 2 * s;
        hready = 1'b1;
      end else if (x[0] == 1'b0) begin
        if (x + 1 < src_width) even_hold[c] = s;
      end else begin
        hsum   = even_hold[c] + s;
        hready = 1'b1;
      end

      // Vertical pair through the line of even-row sums.
      idx = dx * comps + c;
      if (hready && idx < LINE_DEPTH) begin
        if (src_height == 1) begin
          total  = 2 * hsum;
          vready = 1'b1;
        end else if (y[0] == 1'b0) begin
          if (y + 1 < src_height) line_sums[idx] = SUM_W'(hsum);
        end else begin
          total  = line_sums[idx] + hsum;
          vready = 1'b1;
        end
      end

      // Raster position, wrapping at the end of the image.
      c++;
      if (c >= comps) begin
        c = 0;
        x++;
        if (x >= src_width) begin
          x = 0;
          y++;
          if (y >= src_height) y = 0;
        end
      end
      comp = c;
      col  = x;
      row  = y;

      if (vready) begin
        r.value = SAMPLE_W'((total + 2) >> 2);
        r.eoi   = (dx + 1 == dw && dy + 1 == dh && c == 0);
        r.err   = 1'b0;
        awaited.push_back(r);
      end
    endfunction

    task report(string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(dest_comp_t got);
      dest_comp_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result: value %0d eoi %0b error %0b",
                         got.value, got.eoi, got.err));
        return;
      end
      want = awaited.pop_front();
      if (got.value !== want.value)
        report($sformatf("value mismatch: got %0d, want %0d", got.value, want.value));
      if (got.eoi !== want.eoi)
        report($sformatf("end_of_image mismatch: got %0b, want %0b", got.eoi, want.eoi));
      if (got.err !== want.err)
        report($sformatf("config_error mismatch: got %0b, want %0b", got.err, want.err));
    endtask

    task flag_leftovers();
      if (awaited.size() != 0)
        report($sformatf("%0d expected results never arrived", awaited.size()));
    endtask
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]    cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample     = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [SAMPLE_W-1:0] out_value;
  logic                eoi;
  logic                cfg_err;

  halfsize_scoreboard sb = new();
  bit tx_idle    = 1'b1;
  bit rx_idle    = 1'b1;
  int stall_left = 0;

  mipmap_half_downsampler_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_value_o    (out_value),
    .end_of_image_o (eoi),
    .config_error_o (cfg_err)
  );

  // Free-running clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output stall, counted down from the draw made at each transaction.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(dest_comp_t'{out_value, eoi, cfg_err});
      stall_left = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic cfg_write(input logic [CIDX_W-1:0] index, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(index, data);
  endtask

  // Waits for the block to go idle, then writes the registers selected by
  // mask (format, width, height, spare index) and picks new idling modes.
  task automatic configure(input logic [FMT_W-1:0] fmt, input logic [CFG_W-1:0] w,
                           input logic [CFG_W-1:0] h, input int mask);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    case ($urandom_range(0, 3))
      0: begin tx_idle = 1'b0; rx_idle = 1'b0; end
      1: begin tx_idle = 1'b1; rx_idle = 1'b0; end
      2: begin tx_idle = 1'b0; rx_idle = 1'b1; end
      default: begin tx_idle = 1'b1; rx_idle = 1'b1; end
    endcase
    if (mask[0]) cfg_write(REG_FORMAT, CFG_W'(fmt));
    if (mask[1]) cfg_write(REG_WIDTH, w);
    if (mask[2]) cfg_write(REG_HEIGHT, h);
    if (mask[3]) cfg_write(REG_SPARE, CFG_W'($urandom));
    if (mask != 0) begin
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  // One input transaction; with drain set the sender first waits until
  // every awaited result has come out.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit drain);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0 || drain) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(negedge clk);
      while (drain && sb.pending() != 0) @(negedge clk);
      repeat (gap > 1 ? gap - 1 : 0) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(value);
  endtask

  task automatic feed(input int count, input pattern_e pat, input int drain_odds);
    logic [SAMPLE_W-1:0] v;
    for (int k = 0; k < count; k++) begin
      case (pat)
        PAT_FULL:      v = '1;
        PAT_EMPTY:     v = '0;
        PAT_ALTERNATE: v = k[0] ? '0 : '1;
        default:       v = SAMPLE_W'($urandom);
      endcase
      send_sample(v, drain_odds > 0 && $urandom_range(1, drain_odds) == 1);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Random format codes, rejected and accepted.
  function automatic logic [FMT_W-1:0] FMT_FORMAT_BAD();
    return FMT_W'($urandom_range(FMT_BAD_FIRST, FMT_BAD_LAST));
  endfunction

  function automatic logic [FMT_W-1:0] FMT_FORMAT_GOOD();
    return FMT_W'($urandom_range(FMT_RGB, FMT_ALPHA));
  endfunction

  // Stimulus.
  initial begin
    logic [FMT_W-1:0] fmt;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    int               count;
    int               bytes;
    int               random_count;
    pattern_e         pat;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset configuration, extremes of the sample, every format,
    // invalid settings, one-pixel width and height, odd last column and row.
    configure(FMT_RGBA, SIZE_RESET, SIZE_RESET, 0);
    feed(4, PAT_ALTERNATE, 1);
    configure(FMT_LUMINANCE, 2, 2, 7);
    feed(4, PAT_FULL, 0);
    configure(FMT_BAD_LAST, 2, 2, 1);
    feed(2, PAT_RANDOM, 0);
    configure(FMT_ALPHA, 0, 2, 3);
    feed(1, PAT_RANDOM, 0);
    configure(FMT_ALPHA, 3, CFG_W'(CFG_MAX), 6);
    feed(1, PAT_RANDOM, 0);
    configure(FMT_ALPHA, 3, 1, 6);
    feed(3, PAT_RANDOM, 0);
    configure(FMT_ALPHA, 1, 3, 6);
    feed(3, PAT_RANDOM, 0);
    configure(FMT_RGB, 1, 1, 9);
    feed(3, PAT_EMPTY, 0);
    configure(FMT_LUM_ALPHA, 2, 1, 15);
    feed(4, PAT_ALTERNATE, 0);

    // Start of an image at the largest width and at the largest height.
    configure(FMT_LUMINANCE, CFG_W'(DEF_MAX_WIDTH), 1, 7);
    feed(LARGE_CUT, PAT_RANDOM, 0);
    configure(FMT_ALPHA, 1, CFG_W'(DEF_MAX_HEIGHT), 7);
    feed(LARGE_CUT, PAT_RANDOM, 0);

    // Random phases: mostly whole small images, with cut-off images and
    // invalid settings mixed in.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      fmt = ($urandom_range(0, 99) < 8) ? FMT_FORMAT_BAD() : FMT_FORMAT_GOOD();
      case ($urandom_range(0, 19))
        0:       w = $urandom_range(0, 1) ? '0 : CFG_W'($urandom_range(DEF_MAX_WIDTH + 1, CFG_MAX));
        1, 2, 3: w = CFG_W'($urandom_range(9, 64));
        default: w = CFG_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 19))
        0:       h = $urandom_range(0, 1) ? '0 : CFG_W'($urandom_range(DEF_MAX_HEIGHT + 1, CFG_MAX));
        1, 2, 3: h = CFG_W'($urandom_range(9, 24));
        default: h = CFG_W'($urandom_range(1, 8));
      endcase
      configure(fmt, w, h, $urandom_range(1, 15));
      if (!sb.config_ok()) begin
        count = $urandom_range(1, 12);
      end else begin
        bytes = sb.src_width * sb.src_height * sb.pixel_comps();
        if (bytes > PARTIAL_CAP || $urandom_range(0, 6) == 0)
          count = $urandom_range(1, bytes > PARTIAL_CAP ? PARTIAL_CAP : bytes);
        else
          count = bytes * $urandom_range(1, 2);
      end
      case ($urandom_range(0, 19))
        0:       pat = PAT_FULL;
        1:       pat = PAT_EMPTY;
        2:       pat = PAT_ALTERNATE;
        default: pat = PAT_RANDOM;
      endcase
      feed(count, pat, 300);
      random_count += count;
    end

    // Let the last results drain, then give the verdict.
    count = 0;
    while (sb.pending() != 0 && count < 5000) begin
      @(posedge clk);
      count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
